### hdl/cslu_pkg.sv
// Shared types and codes for the C string literal unescape unit.
package cslu_pkg;

  // Result kinds carried on the output tuser.
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_UNTERM = 2'd2;
  localparam logic [1:0] KIND_BADESC = 2'd3;

  // Configuration register indexes.
  localparam logic REG_TERMINATOR = 1'b0;

  localparam logic [7:0] TERMINATOR_RESET = 8'd34;

  // Command queue between the classifier and the result expander.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // One command holds everything a single input byte produces: an optional
  // UTF-8 encoded numeric escape followed by an optional single result.
  typedef struct packed {
    logic        has_utf8;
    logic [31:0] value;
    logic        has_tail;
    logic [7:0]  tail_byte;
    logic [1:0]  tail_kind;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

### hdl/cslu_front.sv
// Front end: accepts literal bytes, tracks the escape state and issues commands.
module cslu_front import cslu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [7:0] in_byte,
  input  logic       in_eoi,
  input  logic [7:0] terminator,
  output logic       push,
  output cmd_t       cmd
);

  localparam logic [2:0] PH_OPEN = 3'd0;
  localparam logic [2:0] PH_BODY = 3'd1;
  localparam logic [2:0] PH_ESC  = 3'd2;
  localparam logic [2:0] PH_HEX  = 3'd3;
  localparam logic [2:0] PH_OCT  = 3'd4;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_X         = 8'h78;
  localparam logic [7:0] CH_0         = 8'h30;
  localparam logic [7:0] CH_7         = 8'h37;

  // Returns {valid, digit value}.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // Returns {valid, byte} for the single-character escapes.
  function automatic logic [8:0] simple_escape(input logic [7:0] c);
    logic [8:0] r;
    r = 9'd0;
    case (c)
      8'h27:   r = {1'b1, 8'h27};
      8'h22:   r = {1'b1, 8'h22};
      8'h3F:   r = {1'b1, 8'h3F};
      8'h5C:   r = {1'b1, 8'h5C};
      8'h43:   r = {1'b1, 8'h1C};
      8'h61:   r = {1'b1, 8'h07};
      8'h62:   r = {1'b1, 8'h08};
      8'h66:   r = {1'b1, 8'h0C};
      8'h6E:   r = {1'b1, 8'h0A};
      8'h72:   r = {1'b1, 8'h0D};
      8'h74:   r = {1'b1, 8'h09};
      8'h76:   r = {1'b1, 8'h0B};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  logic [2:0]  phase_r, phase_nxt;
  logic [31:0] value_r, value_nxt;
  logic [1:0]  oct_left_r, oct_left_nxt;
  logic        do_body;
  logic        is_oct;
  logic [4:0]  hex;
  logic [8:0]  simple;

  always_comb begin
    phase_nxt    = phase_r;
    value_nxt    = value_r;
    oct_left_nxt = oct_left_r;
    do_body      = 1'b0;
    is_oct       = (in_byte >= CH_0) && (in_byte <= CH_7);
    hex          = hex_digit(in_byte);
    simple       = simple_escape(in_byte);
    cmd          = '0;
    cmd.value    = value_r;

    case (phase_r)
      PH_OPEN: begin
        if (in_eoi) begin
          cmd.has_tail  = 1'b1;
          cmd.tail_kind = KIND_UNTERM;
        end else begin
          phase_nxt = PH_BODY;
        end
      end
      PH_BODY: begin
        do_body = 1'b1;
      end
      PH_ESC: begin
        if (in_eoi) begin
          cmd.has_tail  = 1'b1;
          cmd.tail_kind = KIND_UNTERM;
          phase_nxt     = PH_OPEN;
        end else if (in_byte == CH_X) begin
          value_nxt = 32'd0;
          phase_nxt = PH_HEX;
        end else if (is_oct) begin
          value_nxt    = {29'd0, in_byte[2:0]};
          oct_left_nxt = 2'd2;
          phase_nxt    = PH_OCT;
        end else if (simple[8]) begin
          cmd.has_tail  = 1'b1;
          cmd.tail_byte = simple[7:0];
          cmd.tail_kind = KIND_DATA;
          phase_nxt     = PH_BODY;
        end else begin
          cmd.has_tail  = 1'b1;
          cmd.tail_byte = in_byte;
          cmd.tail_kind = KIND_BADESC;
          phase_nxt     = PH_OPEN;
        end
      end
      PH_HEX: begin
        if (!in_eoi && hex[4]) begin
          value_nxt = {value_r[27:0], hex[3:0]};
        end else begin
          cmd.has_utf8 = 1'b1;
          do_body      = 1'b1;
        end
      end
      PH_OCT: begin
        if (!in_eoi && is_oct) begin
          value_nxt    = {value_r[28:0], in_byte[2:0]};
          oct_left_nxt = oct_left_r - 2'd1;
          if (oct_left_r == 2'd1) begin
            cmd.has_utf8 = 1'b1;
            cmd.value    = value_nxt;
            phase_nxt    = PH_BODY;
          end
        end else begin
          cmd.has_utf8 = 1'b1;
          do_body      = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_OPEN;
      end
    endcase

    // A non-digit byte ending a numeric escape is handled again as a body byte.
    if (do_body) begin
      phase_nxt = PH_BODY;
      if (in_eoi) begin
        cmd.has_tail  = 1'b1;
        cmd.tail_kind = KIND_UNTERM;
        phase_nxt     = PH_OPEN;
      end else if (in_byte == terminator) begin
        cmd.has_tail  = 1'b1;
        cmd.tail_kind = KIND_DONE;
        phase_nxt     = PH_OPEN;
      end else if (in_byte == CH_BACKSLASH) begin
        phase_nxt = PH_ESC;
      end else begin
        cmd.has_tail  = 1'b1;
        cmd.tail_byte = in_byte;
        cmd.tail_kind = KIND_DATA;
      end
    end

    push = in_fire && (cmd.has_utf8 || cmd.has_tail);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_OPEN;
      value_r    <= 32'd0;
      oct_left_r <= 2'd0;
    end else if (in_fire) begin
      phase_r    <= phase_nxt;
      value_r    <= value_nxt;
      oct_left_r <= oct_left_nxt;
    end
  end

endmodule

### hdl/cslu_cmd_fifo.sv
// Short command queue between the front end and the result expander.
module cslu_cmd_fifo import cslu_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  cmd_t         push_cmd,
  input  logic         pop,
  output cmd_t         head,
  output fifo_status_t status
);

  cmd_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   count_r, count_nxt;

  assign head         = mem_r[rd_ptr_r];
  assign status.full  = (count_r == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign status.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (FIFO_AW + 1)'(push) - (FIFO_AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### hdl/cslu_back.sv
// Back end: expands each command into result transfers through an output register.
module cslu_back import cslu_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  fifo_status_t fifo_st,
  input  cmd_t         head,
  output logic         pop,
  output logic         busy,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [7:0]   out_byte,
  output logic [1:0]   out_kind,
  output logic         out_last
);

  // Number of bytes in the extended UTF-8 form of v.
  function automatic logic [2:0] utf8_len(input logic [31:0] v);
    logic [2:0] n;
    if (v <= 32'h7F)            n = 3'd1;
    else if (v <= 32'h7FF)      n = 3'd2;
    else if (v <= 32'hFFFF)     n = 3'd3;
    else if (v <= 32'h1FFFFF)   n = 3'd4;
    else if (v <= 32'h3FFFFFF)  n = 3'd5;
    else if (v <= 32'h7FFFFFFF) n = 3'd6;
    else                        n = 3'd7;
    return n;
  endfunction

  // Byte of the encoding with k continuation bytes still to follow it.
  function automatic logic [7:0] utf8_byte(input logic [31:0] v, input logic [2:0] len,
                                           input logic [2:0] k);
    logic [5:0] chunk;
    logic [7:0] r;
    case (k)
      3'd0:    chunk = v[5:0];
      3'd1:    chunk = v[11:6];
      3'd2:    chunk = v[17:12];
      3'd3:    chunk = v[23:18];
      3'd4:    chunk = v[29:24];
      default: chunk = {4'd0, v[31:30]};
    endcase
    if (len == 3'd1) begin
      r = v[7:0];
    end else if (k == len - 3'd1) begin
      case (len)
        3'd2:    r = 8'hC0 | {3'd0, v[10:6]};
        3'd3:    r = 8'hE0 | {4'd0, v[15:12]};
        3'd4:    r = 8'hF0 | {5'd0, v[20:18]};
        3'd5:    r = 8'hF8 | {6'd0, v[25:24]};
        3'd6:    r = 8'hFC | {7'd0, v[30]};
        default: r = 8'hFE;
      endcase
    end else begin
      r = {2'b10, chunk};
    end
    return r;
  endfunction

  cmd_t       cur_r;
  logic       cur_valid_r, cur_valid_nxt;
  logic [2:0] len_r;
  logic [3:0] total_r;
  logic [2:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic [1:0] out_kind_r;
  logic       out_last_r;

  logic       slot_free;
  logic       emit;
  logic       cur_last;
  logic       in_utf8;
  logic [7:0] res_byte;
  logic [1:0] res_kind;
  logic [2:0] head_len;
  logic [3:0] head_total;

  always_comb begin
    slot_free  = !out_valid_r || out_ready;
    emit       = cur_valid_r && slot_free;
    cur_last   = (({1'b0, step_r} + 4'd1) == total_r);
    pop        = !fifo_st.empty && (!cur_valid_r || (emit && cur_last));
    head_len   = utf8_len(head.value);
    head_total = (head.has_utf8 ? {1'b0, head_len} : 4'd0) + {3'd0, head.has_tail};

    in_utf8 = cur_r.has_utf8 && (step_r < len_r);
    if (in_utf8) begin
      res_byte = utf8_byte(cur_r.value, len_r, len_r - 3'd1 - step_r);
      res_kind = KIND_DATA;
    end else begin
      res_byte = cur_r.tail_byte;
      res_kind = cur_r.tail_kind;
    end

    if (pop) begin
      cur_valid_nxt = 1'b1;
      step_nxt      = 3'd0;
    end else if (emit) begin
      cur_valid_nxt = !cur_last && cur_valid_r;
      step_nxt      = step_r + 3'd1;
    end else begin
      cur_valid_nxt = cur_valid_r;
      step_nxt      = step_r;
    end

    out_valid_nxt = slot_free ? cur_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      step_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r   <= head;
      len_r   <= head_len;
      total_r <= head_total;
    end
    if (emit) begin
      out_byte_r <= res_byte;
      out_kind_r <= res_kind;
      out_last_r <= cur_last;
    end
  end

  assign busy      = cur_valid_r;
  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_kind  = out_kind_r;
  assign out_last  = out_last_r;

endmodule

### hdl/c_string_literal_unescape_unit.sv
// Top level of the C string literal unescape unit with its register port.
//
// Bytes of a quoted C literal enter one per cycle on the in_ stream and leave
// decoded on the out_ stream; a numeric escape leaves as extended UTF-8 of up
// to seven bytes. An input byte that yields at most one result is taken every
// cycle. The result expander sends one result per cycle while out_tready is
// high, so an item yielding n results (at most eight) takes n transfers; a
// four-entry command queue absorbs such bursts, and in_tready drops only
// while that queue is full. Results pass through the queue, the expander
// and its output register. No clearing pass follows reset.
module c_string_literal_unescape_unit import cslu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // end_of_input
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast,  // last result of an input transfer
  // Register port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [7:0]   terminator_r;
  logic         cfg_wr;
  logic         in_fire;
  logic         push;
  logic         pop;
  logic         back_busy;
  cmd_t         push_cmd;
  cmd_t         head;
  fifo_status_t fifo_st;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_TERMINATOR) ? {24'd0, terminator_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      terminator_r <= TERMINATOR_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == REG_TERMINATOR)) begin
      terminator_r <= cfg_pwdata[7:0];
    end
  end

  assign in_tready = !fifo_st.full;
  assign in_fire   = in_tvalid && in_tready;

  cslu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_byte    (in_tdata),
    .in_eoi     (in_tlast),
    .terminator (terminator_r),
    .push       (push),
    .cmd        (push_cmd)
  );

  cslu_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (fifo_st)
  );

  cslu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fifo_st   (fifo_st),
    .head      (head),
    .pop       (pop),
    .busy      (back_busy),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_kind  (out_tuser),
    .out_last  (out_tlast)
  );

`ifndef SYNTHESIS
  // Nothing is offered on the result stream right after reset.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  // With the queue empty and the expander idle, a taken result is the final one.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && fifo_st.empty && !back_busy) |=> !out_tvalid)
    else $error("result appeared without a pending command");

  // An idle expander picks up a queued command on the next edge.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!fifo_st.empty && !back_busy) |=> back_busy)
    else $error("queued command not picked up");
`endif

endmodule

### tb/sv/c_string_literal_unescape_unit_tb.sv
// Self-checking testbench for the C string literal unescape unit.
module c_string_literal_unescape_unit_tb import cslu_pkg::*; ();

  localparam int CYCLE_LIMIT     = 200000;
  localparam int ITEMS_PER_PHASE = 34;
  localparam int SETTLE_CYCLES   = 10;
  localparam logic [7:0] BACKSLASH = 8'h5C;

  typedef enum logic [2:0] {
    AWAIT_OPEN,
    IN_BODY,
    IN_ESCAPE,
    IN_HEX,
    IN_OCTAL
  } lit_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       last;
  } decoded_t;

  typedef struct packed {
    logic [7:0] value;
    logic       eoi;
    logic       typed;
    logic [7:0] exp_data;
    logic [1:0] exp_kind;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;  // [7:0] in_byte
  logic        in_tlast = 1'b0;   // end_of_input
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // [7:0] out_byte
  logic [1:0]  out_tuser;         // [1:0] kind
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = 3'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  c_string_literal_unescape_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // Decoder model state and its configuration copy.
  lit_phase_t  lit_phase = AWAIT_OPEN;
  logic [31:0] esc_value = 32'd0;
  logic [1:0]  octal_left = 2'd0;
  logic [7:0]  terminator = TERMINATOR_RESET;

  decoded_t decoded_q[$];
  decoded_t item_results[$];

  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_left = 0;
  int cycle_count = 0;
  int fail_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int settings_used = 0;
  int kind_seen[4] = '{0, 0, 0, 0};

  string SIMPLE_ESCAPES = "'\"?\\abfnrtvC";
  string HEX_CHARS = "0123456789abcdefABCDEF";

  // Byte, end flag, typed flag, typed result byte and kind.
  stim_row_t directed_rows [0:24] = '{
    '{8'h00, 1'b1, 1'b1, 8'h00, KIND_UNTERM},  // end before any opening delimiter
    '{"\"",  1'b0, 1'b0, 8'h00, KIND_DATA},
    '{8'h00, 1'b0, 1'b1, 8'h00, KIND_DATA},
    '{8'hFF, 1'b0, 1'b1, 8'hFF, KIND_DATA},
    '{"\\",  1'b0, 1'b0, 8'h00, KIND_DATA},
    '{"C",   1'b0, 1'b1, 8'h1C, KIND_DATA},
    '{"\\",  1'b0, 1'b0, 8'h00, KIND_DATA},
    '{"x",   1'b0, 1'b0, 8'h00, KIND_DATA},
    '{"\"",  1'b0, 1'b0, 8'h00, KIND_DATA},    // hex escape with no digits, then close
    '{"A",   1'b0, 1'b0, 8'h00, KIND_DATA},
    '{"\\",  1'b0, 1'b0, 8'h00, KIND_DATA},
    '{"7",   1'b0, 1'b0, 8'h00, KIND_DATA},
    '{"7",   1'b0, 1'b0, 8'h00, KIND_DATA},
    '{"7",   1'b0, 1'b0, 8'h00, KIND_DATA},    // third octal digit ends the escape
    '{"\\",  1'b0, 1'b0, 8'h00, KIND_DATA},
    '{"q",   1'b0, 1'b1, "q",   KIND_BADESC},
    '{"\"",  1'b0, 1'b0, 8'h00, KIND_DATA},
    '{"\\",  1'b0, 1'b0, 8'h00, KIND_DATA},
    '{8'hFF, 1'b1, 1'b1, 8'h00, KIND_UNTERM},  // end right after a backslash
    '{"\"",  1'b0, 1'b0, 8'h00, KIND_DATA},
    '{"\\",  1'b0, 1'b0, 8'h00, KIND_DATA},
    '{"x",   1'b0, 1'b0, 8'h00, KIND_DATA},
    '{"F",   1'b0, 1'b0, 8'h00, KIND_DATA},
    '{8'h00, 1'b1, 1'b0, 8'h00, KIND_DATA},    // end inside a hex escape
    '{8'h5A, 1'b1, 1'b1, 8'h00, KIND_UNTERM}
  };

  function automatic void add_result(logic [7:0] data, logic [1:0] kind);
    decoded_t r;
    r.data = data;
    r.kind = kind;
    r.last = 1'b0;
    if (item_results.size() < 8) item_results.push_back(r);
  endfunction

  // Extended UTF-8: up to seven bytes, lead 0xFE above 31 bits.
  function automatic void add_utf8(logic [31:0] v);
    int tail;
    logic [7:0] lead;
    if (v <= 32'h7F) begin
      add_result(v[7:0], KIND_DATA);
      return;
    end
    if (v <= 32'h7FF) begin
      lead = 8'hC0 | {3'b000, v[10:6]};
      tail = 1;
    end else if (v <= 32'hFFFF) begin
      lead = 8'hE0 | {4'b0000, v[15:12]};
      tail = 2;
    end else if (v <= 32'h1FFFFF) begin
      lead = 8'hF0 | {5'b00000, v[20:18]};
      tail = 3;
    end else if (v <= 32'h3FFFFFF) begin
      lead = 8'hF8 | {6'b000000, v[25:24]};
      tail = 4;
    end else if (v <= 32'h7FFFFFFF) begin
      lead = 8'hFC | {7'b0000000, v[30]};
      tail = 5;
    end else begin
      lead = 8'hFE;
      tail = 6;
    end
    add_result(lead, KIND_DATA);
    for (int k = tail - 1; k >= 0; k--) begin
      add_result(8'h80 | {2'b00, 6'(v >> (6 * k))}, KIND_DATA);
    end
  endfunction

  function automatic int hex_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    return -1;
  endfunction

  function automatic void body_char(logic [7:0] c, logic eoi);
    if (eoi) begin
      add_result(8'h00, KIND_UNTERM);
      lit_phase = AWAIT_OPEN;
    end else if (c == terminator) begin
      add_result(8'h00, KIND_DONE);
      lit_phase = AWAIT_OPEN;
    end else if (c == BACKSLASH) begin
      lit_phase = IN_ESCAPE;
    end else begin
      add_result(c, KIND_DATA);
    end
  endfunction

  function automatic void escape_char(logic [7:0] c, logic eoi);
    logic [7:0] r;
    logic       simple;
    simple = 1'b1;
    r = 8'h00;
    if (eoi) begin
      add_result(8'h00, KIND_UNTERM);
      lit_phase = AWAIT_OPEN;
      return;
    end
    case (c)
      "'":  r = 8'h27;
      "\"": r = 8'h22;
      "?":  r = 8'h3F;
      "\\": r = 8'h5C;
      "C":  r = 8'h1C;
      "a":  r = 8'h07;
      "b":  r = 8'h08;
      "f":  r = 8'h0C;
      "n":  r = 8'h0A;
      "r":  r = 8'h0D;
      "t":  r = 8'h09;
      "v":  r = 8'h0B;
      default: simple = 1'b0;
    endcase
    if (simple) begin
      add_result(r, KIND_DATA);
      lit_phase = IN_BODY;
    end else if (c == "x") begin
      esc_value = 32'd0;
      lit_phase = IN_HEX;
    end else if (c >= "0" && c <= "7") begin
      esc_value = {29'd0, c[2:0]};
      octal_left = 2'd2;
      lit_phase = IN_OCTAL;
    end else begin
      add_result(c, KIND_BADESC);
      lit_phase = AWAIT_OPEN;
    end
  endfunction

  // Results that one accepted input byte produces; they land in item_results.
  function automatic void decode_byte(logic [7:0] c, logic eoi);
    int d;
    item_results.delete();
    case (lit_phase)
      AWAIT_OPEN: begin
        if (eoi) add_result(8'h00, KIND_UNTERM);
        else lit_phase = IN_BODY;
      end
      IN_BODY:   body_char(c, eoi);
      IN_ESCAPE: escape_char(c, eoi);
      IN_HEX: begin
        d = eoi ? -1 : hex_value(c);
        if (d >= 0) begin
          esc_value = {esc_value[27:0], 4'(d)};
        end else begin
          add_utf8(esc_value);
          lit_phase = IN_BODY;
          body_char(c, eoi);
        end
      end
      IN_OCTAL: begin
        if (!eoi && c >= "0" && c <= "7") begin
          esc_value = {esc_value[28:0], c[2:0]};
          octal_left = octal_left - 2'd1;
          if (octal_left == 2'd0) begin
            add_utf8(esc_value);
            lit_phase = IN_BODY;
          end
        end else begin
          add_utf8(esc_value);
          lit_phase = IN_BODY;
          body_char(c, eoi);
        end
      end
      default: lit_phase = AWAIT_OPEN;
    endcase
    if (item_results.size() > 0) item_results[item_results.size() - 1].last = 1'b1;
  endfunction

  // Offers one byte, waits for its transfer and queues its results or the typed one.
  task automatic send_byte(input logic [7:0] value, input logic eoi,
                           input logic typed = 1'b0, input logic [7:0] exp_data = 8'h00,
                           input logic [1:0] exp_kind = KIND_DATA);
    decoded_t typed_r;
    @(negedge clk);
    while (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= value;
    in_tlast <= eoi;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    decode_byte(value, eoi);
    if (typed) begin
      typed_r.data = exp_data;
      typed_r.kind = exp_kind;
      typed_r.last = 1'b1;
      decoded_q.push_back(typed_r);
    end else begin
      foreach (item_results[k]) decoded_q.push_back(item_results[k]);
    end
  endtask

  // Stops offering bytes and lets every queued result come out.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_terminator(input logic [7:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {REG_TERMINATOR, 2'b00};
    cfg_pwdata <= {24'd0, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    terminator = value;
    settings_used++;
    // Read the register back in a second transfer.
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[7:0] !== value) begin
      $error("terminator_char readback expected %h got %h", value, cfg_prdata[7:0]);
      fail_count++;
    end
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic send_plain();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == terminator) c = c ^ 8'h01;
    if (c == BACKSLASH && $urandom_range(0, 9) != 0) c = "z";
    send_byte(c, 1'b0);
  endtask

  // One quoted literal with random content; mostly well formed.
  task automatic send_literal();
    int n_tokens;
    int pick;
    int n_digits;
    send_byte(8'($urandom_range(0, 255)), 1'b0);
    n_tokens = $urandom_range(0, 8);
    repeat (n_tokens) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_plain();
      end else if (pick < 60) begin
        send_byte(BACKSLASH, 1'b0);
        send_byte(SIMPLE_ESCAPES[$urandom_range(0, 11)], 1'b0);
      end else if (pick < 75) begin
        send_byte(BACKSLASH, 1'b0);
        send_byte("x", 1'b0);
        n_digits = ($urandom_range(0, 2) == 0) ? $urandom_range(5, 10) : $urandom_range(0, 4);
        repeat (n_digits) send_byte(HEX_CHARS[$urandom_range(0, 21)], 1'b0);
      end else if (pick < 90) begin
        send_byte(BACKSLASH, 1'b0);
        repeat ($urandom_range(1, 3)) send_byte(8'("0" + $urandom_range(0, 7)), 1'b0);
      end else if (pick < 95) begin
        send_byte(BACKSLASH, 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 2) == 0);
      end
    end
    pick = $urandom_range(0, 99);
    if (pick < 85) send_byte(terminator, 1'b0);
    else if (pick < 95) send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Receiver: a long hold-off when requested, else random stalls.
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      out_tready <= 1'b0;
      hold_off_left--;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    decoded_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, decoded_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      kind_seen[out_tuser]++;
      if (decoded_q.size() == 0) begin
        $error("unexpected result: out_byte %h kind %0d last %b",
               out_tdata, out_tuser, out_tlast);
        fail_count++;
      end else begin
        want = decoded_q.pop_front();
        if (out_tdata !== want.data) begin
          $error("out_byte expected %h got %h", want.data, out_tdata);
          fail_count++;
        end
        if (out_tuser !== want.kind) begin
          $error("kind expected %0d got %0d", want.kind, out_tuser);
          fail_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last expected %b got %b", want.last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  initial begin
    logic [7:0] phase_terms [0:5];
    int target;
    phase_terms = '{8'd34, 8'h00, 8'hFF, BACKSLASH, 8'h00, 8'h27};
    phase_terms[4] = 8'($urandom_range(0, 255));

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].value, directed_rows[i].eoi, directed_rows[i].typed,
                directed_rows[i].exp_data, directed_rows[i].exp_kind);
    end

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      write_terminator(phase_terms[p]);
      case (p % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin sender_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      // The first phase starts against a blocked receiver so the command queue fills.
      if (p == 0) hold_off_left = 200;
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) begin
        send_literal();
        if (p == 2 && items_sent >= target - ITEMS_PER_PHASE / 2 && decoded_q.size() > 4)
          wait_drained();
      end
    end
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Ran %0d input transfers and %0d results under %0d terminator settings.",
             items_sent, results_seen, settings_used);
    $display("Result kinds: data %0d, complete %0d, unterminated %0d, unknown escape %0d.",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
    if (fail_count == 0 && decoded_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
